>>> hdl/mpb_pkg.sv
// ============================================================================
// Mask pixel to BGR888 package
// Shared widths, register indexes, the configuration bus type and the
// arithmetic helpers used by the pixel conversion pipeline.
// ============================================================================
package mpb_pkg;

    localparam int PIX_W      = 32;
    localparam int FIELD_W    = 32;
    localparam int SHIFT_W    = 5;
    localparam int COLOUR_W   = 8;
    localparam int NUM_W      = FIELD_W + COLOUR_W;
    localparam int NUM_CH     = 3;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = COLOUR_W / DIV_STEPS;
    localparam int QIDX_W     = 3;
    localparam int PIPE_DEPTH = 3 + DIV_STAGES;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int BPP_W      = 3;

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    typedef enum logic [1:0] {
        REG_RED_MASK   = 2'd0,
        REG_GREEN_MASK = 2'd1,
        REG_BLUE_MASK  = 2'd2,
        REG_BPP        = 2'd3
    } reg_idx_t;

    localparam logic [BPP_W-1:0] BPP_2 = 3'd2;
    localparam logic [BPP_W-1:0] BPP_3 = 3'd3;
    localparam logic [BPP_W-1:0] BPP_4 = 3'd4;

    localparam logic [FIELD_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [FIELD_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [FIELD_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;
    localparam logic [FIELD_W-1:0] TOP_RST        = 32'h0000_00FF;
    localparam logic [SHIFT_W-1:0] RED_TZ_RST     = 5'd16;
    localparam logic [SHIFT_W-1:0] GREEN_TZ_RST   = 5'd8;
    localparam logic [SHIFT_W-1:0] BLUE_TZ_RST    = 5'd0;

    typedef struct packed {
        logic [NUM_CH-1:0][FIELD_W-1:0] mask;
        logic [NUM_CH-1:0][SHIFT_W-1:0] tz;
        logic [NUM_CH-1:0][FIELD_W-1:0] top;
        logic                           err;
    } cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0]    rem;
        logic [COLOUR_W-1:0] quo;
    } div_state_t;

    function automatic logic [SHIFT_W-1:0] trailing_zeros(input logic [FIELD_W-1:0] m);
        logic [SHIFT_W-1:0] n;
        n = '0;
        for (int i = FIELD_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                n = SHIFT_W'(i);
            end
        end
        return n;
    endfunction

    function automatic logic mask_contiguous(input logic [FIELD_W-1:0] m);
        logic [FIELD_W-1:0] lowest;
        lowest = m & (~m + FIELD_W'(1));
        return (m != '0) && (((m + lowest) & m) == '0);
    endfunction

    function automatic div_state_t div_steps(input div_state_t st_in,
                                             input logic [FIELD_W-1:0] divisor,
                                             input int first_bit);
        div_state_t         st;
        logic [NUM_W-1:0]   d;
        logic [QIDX_W-1:0]  bit_idx;
        st = st_in;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            bit_idx = QIDX_W'(first_bit - j);
            d = NUM_W'(divisor) << bit_idx;
            if (st.rem >= d)
            begin
                st.rem          = st.rem - d;
                st.quo[bit_idx] = 1'b1;
            end
        end
        return st;
    endfunction

endpackage

>>> hdl/mpb_cfg.sv
// ============================================================================
// Mask pixel to BGR888 configuration registers
// Register file on the APB port, plus the derived shift, field range and
// error flag, registered from the masks and pixel size, the range after the shift.
// ============================================================================
module mpb_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpb_pkg::ADDR_W-1:0]  paddr,
    input  logic [mpb_pkg::DATA_W-1:0]  pwdata,
    output logic [mpb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mpb_pkg::cfg_t               cfg
);
    import mpb_pkg::*;

    logic [NUM_CH-1:0][FIELD_W-1:0] mask_reg;
    logic [NUM_CH-1:0][FIELD_W-1:0] mask_next;
    logic [BPP_W-1:0]               bpp_reg;
    logic [BPP_W-1:0]               bpp_next;
    logic [NUM_CH-1:0][SHIFT_W-1:0] tz_reg;
    logic [NUM_CH-1:0][SHIFT_W-1:0] tz_next;
    logic [NUM_CH-1:0][FIELD_W-1:0] top_reg;
    logic [NUM_CH-1:0][FIELD_W-1:0] top_next;
    logic                           err_reg;
    logic                           err_next;
    logic                           wr_en;
    reg_idx_t                       idx;
    logic [FIELD_W-1:0]             all_masks;
    logic                           size_err;
    logic                           shape_err;
    logic                           overlap_err;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        mask_next = mask_reg;
        bpp_next  = bpp_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_RED_MASK:   mask_next[CH_RED]   = pwdata;
                REG_GREEN_MASK: mask_next[CH_GREEN] = pwdata;
                REG_BLUE_MASK:  mask_next[CH_BLUE]  = pwdata;
                REG_BPP:        bpp_next            = pwdata[BPP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RED_MASK:   prdata = mask_reg[CH_RED];
            REG_GREEN_MASK: prdata = mask_reg[CH_GREEN];
            REG_BLUE_MASK:  prdata = mask_reg[CH_BLUE];
            REG_BPP:        prdata = DATA_W'(bpp_reg);
        endcase
    end

    always_comb
    begin
        all_masks = mask_reg[CH_RED] | mask_reg[CH_GREEN] | mask_reg[CH_BLUE];
        unique case (bpp_reg)
            BPP_2:   size_err = (all_masks[FIELD_W-1:16] != '0);
            BPP_3:   size_err = (all_masks[FIELD_W-1:24] != '0);
            BPP_4:   size_err = 1'b0;
            default: size_err = 1'b1;
        endcase
        shape_err = !mask_contiguous(mask_reg[CH_RED])
                 || !mask_contiguous(mask_reg[CH_GREEN])
                 || !mask_contiguous(mask_reg[CH_BLUE]);
        overlap_err = ((mask_reg[CH_RED] & mask_reg[CH_GREEN]) != '0)
                   || ((mask_reg[CH_RED] & mask_reg[CH_BLUE]) != '0)
                   || ((mask_reg[CH_GREEN] & mask_reg[CH_BLUE]) != '0);
        err_next = size_err || shape_err || overlap_err;
        for (int c = 0; c < NUM_CH; c++)
        begin
            tz_next[c]  = trailing_zeros(mask_reg[c]);
            top_next[c] = mask_reg[c] >> tz_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[CH_RED]   <= RED_MASK_RST;
            mask_reg[CH_GREEN] <= GREEN_MASK_RST;
            mask_reg[CH_BLUE]  <= BLUE_MASK_RST;
            bpp_reg            <= BPP_4;
            tz_reg[CH_RED]     <= RED_TZ_RST;
            tz_reg[CH_GREEN]   <= GREEN_TZ_RST;
            tz_reg[CH_BLUE]    <= BLUE_TZ_RST;
            top_reg[CH_RED]    <= TOP_RST;
            top_reg[CH_GREEN]  <= TOP_RST;
            top_reg[CH_BLUE]   <= TOP_RST;
            err_reg            <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            bpp_reg  <= bpp_next;
            tz_reg   <= tz_next;
            top_reg  <= top_next;
            err_reg  <= err_next;
        end
    end

    assign cfg.mask = mask_reg;
    assign cfg.tz   = tz_reg;
    assign cfg.top  = top_reg;
    assign cfg.err  = err_reg;

`ifndef SYNTHESIS
    // Once the registers have settled, a usable configuration has every
    // field range ending in a set bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(wr_en, 1) && !$past(wr_en, 2) && !$past(wr_en, 3) && !err_reg)
        |-> (top_reg[CH_RED][0] && top_reg[CH_GREEN][0] && top_reg[CH_BLUE][0]))
        else $error("derived field range not contiguous on a good configuration");
`endif

endmodule

>>> hdl/mpb_chan.sv
// ============================================================================
// Mask pixel to BGR888 colour channel
// Extracts one colour field, forms field*255 plus half the range, and divides
// by the range in a restoring divider of two quotient bits per stage.
// ============================================================================
module mpb_chan
(
    input  logic                          clk,
    input  logic [mpb_pkg::PIX_W-1:0]     pixel,
    input  logic [mpb_pkg::FIELD_W-1:0]   mask,
    input  logic [mpb_pkg::SHIFT_W-1:0]   tz,
    input  logic [mpb_pkg::FIELD_W-1:0]   top,
    output logic [mpb_pkg::COLOUR_W-1:0]  quotient
);
    import mpb_pkg::*;

    logic [FIELD_W-1:0] field_reg;
    logic [FIELD_W-1:0] field_next;
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   num_next;
    div_state_t         stage_reg  [DIV_STAGES];
    div_state_t         stage_next [DIV_STAGES];

    assign field_next = (pixel & mask) >> tz;
    assign num_next   = {field_reg, {COLOUR_W{1'b0}}} - NUM_W'(field_reg)
                      + NUM_W'(top >> 1);

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        div_state_t st_in;
        if (s == 0)
        begin : g_first
            assign st_in = '{rem: num_reg, quo: '0};
        end
        else
        begin : g_next
            assign st_in = stage_reg[s-1];
        end
        assign stage_next[s] = div_steps(st_in, top, COLOUR_W - 1 - s * DIV_STEPS);
    end

    always_ff @(posedge clk)
    begin
        field_reg <= field_next;
        num_reg   <= num_next;
        stage_reg <= stage_next;
    end

    assign quotient = stage_reg[DIV_STAGES-1].quo;

endmodule

>>> hdl/mask_pixel_to_bgr888.sv
// ============================================================================
// Mask pixel to BGR888 converter
// Turns a raw bitmask pixel word into blue, green and red bytes with rounding,
// flagging an unusable mask configuration.
// ============================================================================
// Throughput: one request per cycle; busy stays low, as every stage advances
// each cycle through the input register, field extract, scale and four divider
// stages of two quotient bits each.
// Reset: rst_n clears the pipeline valid bits and restores the register defaults.
// A register write is reflected in results for requests taken from the next cycle.
module mask_pixel_to_bgr888
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mpb_pkg::PIX_W-1:0]     pixel_word,
    output logic                          done,
    output logic [mpb_pkg::COLOUR_W-1:0]  blue_out,
    output logic [mpb_pkg::COLOUR_W-1:0]  green_out,
    output logic [mpb_pkg::COLOUR_W-1:0]  red_out,
    output logic                          config_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpb_pkg::ADDR_W-1:0]    paddr,
    input  logic [mpb_pkg::DATA_W-1:0]    pwdata,
    output logic [mpb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import mpb_pkg::*;

    cfg_t                            cfg;
    logic                            accept;
    logic [PIX_W-1:0]                pix_reg;
    logic [PIPE_DEPTH-1:0]           valid_reg;
    logic [PIPE_DEPTH-1:0]           valid_next;
    logic [NUM_CH-1:0][COLOUR_W-1:0] quot;
    logic [NUM_CH-1:0][COLOUR_W-1:0] colour_reg;
    logic [NUM_CH-1:0][COLOUR_W-1:0] colour_next;
    logic                            err_reg;
    logic                            done_reg;

    mpb_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_chan
        mpb_chan u_chan
        (
            .clk      (clk),
            .pixel    (pix_reg),
            .mask     (cfg.mask[c]),
            .tz       (cfg.tz[c]),
            .top      (cfg.top[c]),
            .quotient (quot[c])
        );
    end

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], accept};

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            colour_next[c] = cfg.err ? '0 : quot[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg    <= pixel_word;
        colour_reg <= colour_next;
        err_reg    <= cfg.err;
    end

    assign done         = done_reg;
    assign blue_out     = colour_reg[CH_BLUE];
    assign green_out    = colour_reg[CH_GREEN];
    assign red_out      = colour_reg[CH_RED];
    assign config_error = err_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_DEPTH + 1))
        else $error("result strobed without a matching request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && config_error) |-> (blue_out == '0 && green_out == '0 && red_out == '0))
        else $error("colour bytes not cleared on a configuration error");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (config_error == cfg.err))
        else $error("error flag does not match the configuration in force");
`endif

endmodule
